[src/pcf_pkg.sv]
`timescale 1ns / 1ps

package pcf_pkg;

   // input item kinds
   localparam logic [1:0] KIND_BUS_READ   = 2'd0;
   localparam logic [1:0] KIND_BYTE_WRITE = 2'd1;
   localparam logic [1:0] KIND_CARD_RESET = 2'd2;

   // configuration register indexes
   localparam logic CSR_PRINTER_ENABLED = 1'b0;
   localparam logic CSR_ACCENT_DEFAULT  = 1'b1;

   // character and filter constants (7-bit codes, 8-bit bytes and masks, 5-bit control char)
   localparam logic [6:0] CHR_CR     = 7'h0D;
   localparam logic [6:0] CHR_LT     = 7'h3C;
   localparam logic [6:0] CHR_GT     = 7'h3E;
   localparam logic [6:0] CMD_HIGH   = 7'h48;  // H
   localparam logic [6:0] CMD_CRLF   = 7'h49;  // I
   localparam logic [6:0] CMD_NOCRLF = 7'h4B;  // K
   localparam logic [6:0] CMD_ABIC   = 7'h50;  // P
   localparam logic [6:0] CMD_PLAIN  = 7'h58;  // X
   localparam logic [6:0] CMD_ACCENT = 7'h4D;  // M
   localparam logic [6:0] CMD_DEFLT  = 7'h40;  // @
   localparam logic [6:0] CMD_NOCTRL = 7'h5A;  // Z
   localparam logic [6:0] CHR_SPACE  = 7'h20;
   localparam logic [7:0] CHR_BS     = 8'h08;
   localparam logic [6:0] CHR_LF     = 7'h0A;
   localparam logic [7:0] CAPS_DELTA = 8'h20;
   localparam logic [4:0] CTRL_RESET = 5'd9;
   localparam logic [7:0] MASK_7BIT  = 8'h7F;
   localparam logic [7:0] MASK_8BIT  = 8'hFF;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       command_mode;
      logic [4:0] control_char;
      logic       pass_high_bit;
      logic       crlf_enable;
      logic       abicomp_mode;
      logic       accent_mode;
      logic       upper_next;
      logic       literal_next;
   } state_type;

   // up to three printer bytes for one input item
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;
   } result_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] abicomp;
      logic [7:0] letter;
      logic [7:0] mark;
   } accent_type;

   // accent punctuation lookup
   function automatic accent_type accent_lookup(input logic [6:0] key);
      accent_type a;
      a = '{hit: 1'b1, abicomp: 8'h00, letter: 8'h00, mark: 8'h00};
      case (key)
         7'h5F: begin a.abicomp = 8'hC1; a.letter = 8'h61; a.mark = 8'h60; end
         7'h40: begin a.abicomp = 8'hC2; a.letter = 8'h61; a.mark = 8'h27; end
         7'h5C: begin a.abicomp = 8'hC3; a.letter = 8'h61; a.mark = 8'h5E; end
         7'h5B: begin a.abicomp = 8'hC4; a.letter = 8'h61; a.mark = 8'h7E; end
         7'h5D: begin a.abicomp = 8'hC6; a.letter = 8'h63; a.mark = 8'h2C; end
         7'h60: begin a.abicomp = 8'hC8; a.letter = 8'h65; a.mark = 8'h27; end
         7'h26: begin a.abicomp = 8'hC9; a.letter = 8'h65; a.mark = 8'h5E; end
         7'h7B: begin a.abicomp = 8'hCC; a.letter = 8'h69; a.mark = 8'h27; end
         7'h7E: begin a.abicomp = 8'hD1; a.letter = 8'h6F; a.mark = 8'h27; end
         7'h7D: begin a.abicomp = 8'hD2; a.letter = 8'h6F; a.mark = 8'h5E; end
         7'h23: begin a.abicomp = 8'hD3; a.letter = 8'h6F; a.mark = 8'h7E; end
         7'h7C: begin a.abicomp = 8'hD7; a.letter = 8'h75; a.mark = 8'h27; end
         default: a.hit = 1'b0;
      endcase
      return a;
   endfunction

endpackage

[src/pcf_filter.sv]
`timescale 1ns / 1ps

module pcf_filter (
   input  pcf_pkg::req_type    req,
   input  pcf_pkg::state_type  st,
   input  logic                printer_enabled,
   input  logic                accent_default,
   output pcf_pkg::state_type  st_in,
   output pcf_pkg::result_type res
);

   logic [7:0]          v;
   logic [6:0]          low;
   pcf_pkg::accent_type acc;

   // masked byte and accent lookup
   always_comb begin
      v   = req.data_byte & (st.pass_high_bit ? pcf_pkg::MASK_8BIT : pcf_pkg::MASK_7BIT);
      low = v[6:0];
      acc = pcf_pkg::accent_lookup(low);
   end

   // next state and printer bytes
   always_comb begin
      st_in     = st;
      res.bytes = '0;
      res.count = 2'd0;
      if (req.kind == pcf_pkg::KIND_CARD_RESET) begin
         st_in.control_char  = pcf_pkg::CTRL_RESET;
         st_in.accent_mode   = accent_default;
         st_in.abicomp_mode  = 1'b0;
         st_in.pass_high_bit = 1'b0;
         st_in.crlf_enable   = 1'b1;
      end else if (req.kind == pcf_pkg::KIND_BYTE_WRITE && printer_enabled) begin
         if (low == {2'b00, st.control_char} && st.control_char != 5'd0) begin
            st_in.command_mode = 1'b1;
         end else if (st.command_mode) begin
            // digits are swallowed and keep command mode
            if (!(low inside {[7'h30:7'h39]})) begin
               st_in.command_mode = 1'b0;
               if (low < pcf_pkg::CHR_SPACE && low != pcf_pkg::CHR_CR) begin
                  st_in.control_char = low[4:0];
               end else begin
                  case (low)
                     pcf_pkg::CMD_HIGH:   st_in.pass_high_bit = 1'b1;
                     pcf_pkg::CMD_CRLF:   st_in.crlf_enable   = 1'b1;
                     pcf_pkg::CMD_NOCRLF: st_in.crlf_enable   = 1'b0;
                     pcf_pkg::CMD_ABIC:   st_in.abicomp_mode  = 1'b1;
                     pcf_pkg::CMD_PLAIN: begin
                        st_in.pass_high_bit = 1'b0;
                        st_in.abicomp_mode  = 1'b0;
                     end
                     pcf_pkg::CMD_ACCENT: begin
                        st_in.accent_mode  = !st.accent_mode;
                        st_in.abicomp_mode = 1'b0;
                     end
                     pcf_pkg::CMD_DEFLT: begin
                        st_in.pass_high_bit = 1'b0;
                        st_in.crlf_enable   = 1'b1;
                        st_in.abicomp_mode  = 1'b0;
                        st_in.accent_mode   = accent_default;
                     end
                     pcf_pkg::CMD_NOCTRL: st_in.control_char = 5'd0;
                     default: ;
                  endcase
               end
            end
         end else begin
            // printable path
            res.bytes[0] = v;
            res.count    = 2'd1;
            if (st.accent_mode && !st.literal_next) begin
               if (acc.hit) begin
                  if (st.abicomp_mode) begin
                     res.bytes[0] = acc.abicomp;
                  end else begin
                     res.bytes[0] = acc.letter;
                     res.bytes[1] = pcf_pkg::CHR_BS;
                     res.bytes[2] = acc.mark;
                     res.count    = 2'd3;
                  end
               end
               if (low == pcf_pkg::CHR_LT) begin
                  st_in.literal_next = 1'b1;
                  res.count          = 2'd0;
               end else if (low == pcf_pkg::CHR_GT) begin
                  st_in.upper_next = 1'b1;
                  res.count        = 2'd0;
               end else if (st.upper_next) begin
                  st_in.upper_next = 1'b0;
                  res.bytes[0]     = res.bytes[0] - pcf_pkg::CAPS_DELTA;
               end
            end else if (st.literal_next) begin
               st_in.literal_next = 1'b0;
            end
            // line feed after carriage return
            if (low == pcf_pkg::CHR_CR && st.crlf_enable) begin
               res.bytes[1] = {st.pass_high_bit, pcf_pkg::CHR_LF};
               res.count    = 2'd2;
            end
         end
      end
   end

endmodule

[src/printer_card_char_filter.sv]
`timescale 1ns / 1ps

// Character filter of a parallel printer card. One item enters per cycle,
// when req_ready is high, into an input register; the filter then updates
// the card state and loads zero to three printer bytes into a result buffer
// that hands out one byte per cycle while rsp_ready is high. A new item is
// processed only once the buffer is empty or its last byte is taken, the
// limit being the single-byte result port draining the buffer. The first
// byte passes the input register and then the result buffer. The user must
// write configuration through csr_we, csr_index and csr_wdata only while
// no item is in flight; the block itself does not enforce this.
module printer_card_char_filter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pcf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pcf_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic             csr_wdata
);

   logic                printer_enabled_ff;
   logic                accent_default_ff;
   pcf_pkg::state_type  st_ff, st_in;
   pcf_pkg::req_type    req_ff;
   logic                req_valid_ff;
   pcf_pkg::result_type res;
   logic [2:0][7:0]     buf_bytes_ff;
   logic [1:0]          buf_cnt_ff;
   logic [1:0]          buf_idx_ff;
   logic                buf_valid_ff;
   logic                rsp_last;
   logic                buf_free;
   logic                proc_fire;

   // result buffer handshake
   assign rsp_last  = (buf_idx_ff == buf_cnt_ff - 2'd1);
   assign buf_free  = !buf_valid_ff || (rsp_ready && rsp_last);
   assign proc_fire = req_valid_ff && buf_free;
   assign req_ready = !req_valid_ff || proc_fire;

   assign rsp_valid         = buf_valid_ff;
   assign rsp_data.out_byte = buf_bytes_ff[buf_idx_ff];
   assign rsp_data.last     = rsp_last;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         printer_enabled_ff <= 1'b0;
         accent_default_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            pcf_pkg::CSR_PRINTER_ENABLED: printer_enabled_ff <= csr_wdata;
            pcf_pkg::CSR_ACCENT_DEFAULT:  accent_default_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_ff <= req_data;
      end
   end

   pcf_filter u_filter (
      .req             (req_ff),
      .st              (st_ff),
      .printer_enabled (printer_enabled_ff),
      .accent_default  (accent_default_ff),
      .st_in           (st_in),
      .res             (res)
   );

   // card state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '{command_mode: 1'b0, control_char: pcf_pkg::CTRL_RESET,
                    pass_high_bit: 1'b0, crlf_enable: 1'b1, abicomp_mode: 1'b0,
                    accent_mode: 1'b0, upper_next: 1'b0, literal_next: 1'b0};
      end else if (proc_fire) begin
         st_ff <= st_in;
      end
   end

   // result buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         buf_cnt_ff   <= 2'd0;
         buf_idx_ff   <= 2'd0;
      end else if (proc_fire && res.count != 2'd0) begin
         buf_valid_ff <= 1'b1;
         buf_cnt_ff   <= res.count;
         buf_idx_ff   <= 2'd0;
      end else if (buf_valid_ff && rsp_ready) begin
         if (rsp_last) begin
            buf_valid_ff <= 1'b0;
         end else begin
            buf_idx_ff <= buf_idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (proc_fire && res.count != 2'd0) begin
         buf_bytes_ff <= res.bytes;
      end
   end

   // buffer index stays inside the loaded count
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      buf_valid_ff |-> (buf_cnt_ff != 2'd0 && buf_idx_ff < buf_cnt_ff))
      else $error("result buffer index out of range");

   // a non-final byte is always followed by another byte of the same item
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> rsp_valid)
      else $error("result sequence broken before last byte");

   // card reset restores the control character
   a_card_reset: assert property (@(posedge clock) disable iff (reset)
      (proc_fire && req_ff.kind == pcf_pkg::KIND_CARD_RESET)
      |=> st_ff.control_char == pcf_pkg::CTRL_RESET)
      else $error("card reset did not restore control character");

   // no item leaves the input register while a buffered sequence is mid-way
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (buf_valid_ff && !(rsp_ready && rsp_last)) |-> !proc_fire)
      else $error("item processed while result buffer busy");

endmodule
